[hw/rtl/source_tokenizer_macros.svh]
// ----------------------------------------------------------------------------
// source_tokenizer_macros.svh
// Assertion macros shared by the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/st_pkg.sv]
// ----------------------------------------------------------------------------
// st_pkg
// Types and token kind codes for the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package st_pkg;

  localparam logic [3:0] KIND_ID     = 4'd0;
  localparam logic [3:0] KIND_INT    = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_EQUALS = 4'd3;
  localparam logic [3:0] KIND_SEMI   = 4'd4;
  localparam logic [3:0] KIND_LPAREN = 4'd5;
  localparam logic [3:0] KIND_RPAREN = 4'd6;
  localparam logic [3:0] KIND_COMMA  = 4'd7;
  localparam logic [3:0] KIND_EOF    = 4'd8;

  localparam int ST_RES_DEPTH = 4;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] text_char;
    logic       first_char;
    logic       last_char;
    logic       empty_token;
    logic       last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

`default_nettype wire

[hw/rtl/st_scan.sv]
// ----------------------------------------------------------------------------
// st_scan
// Scanner state and per-character step; yields up to two results per item.
// ----------------------------------------------------------------------------
`default_nettype none

module st_scan import st_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output push_t      push
);

  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_ID         = 3'd1;
  localparam logic [2:0] MODE_NUM        = 3'd2;
  localparam logic [2:0] MODE_STR        = 3'd3;
  localparam logic [2:0] MODE_LINE       = 3'd4;
  localparam logic [2:0] MODE_SLASH      = 3'd5;
  localparam logic [2:0] MODE_BLOCK      = 3'd6;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd7;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  logic [2:0] mode_r, mode_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_first_r, held_first_nxt;
  logic [1:0] held_kind_r, held_kind_nxt;
  logic       str_text_r, str_text_nxt;

  logic       is_dig, is_let;
  logic       idle_put_v, idle_hold_v, idle_str_clr;
  logic [3:0] idle_kind;
  logic [1:0] idle_hold_kind;
  logic [2:0] idle_mode;
  res_t       held_res, idle_res, empty_res, eof_res;
  res_t       a, b;
  logic       a_v, b_v, use_idle;
  push_t      step;

  assign is_dig = (char_code inside {[8'h30:8'h39]});
  assign is_let = (char_code inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (char_code == CH_UNDER);

  // token start decode with nothing in progress
  always_comb begin
    idle_put_v     = 1'b0;
    idle_hold_v    = 1'b0;
    idle_str_clr   = 1'b0;
    idle_kind      = KIND_ID;
    idle_hold_kind = KIND_ID[1:0];
    idle_mode      = MODE_IDLE;
    if (is_dig) begin
      idle_hold_v    = 1'b1;
      idle_hold_kind = KIND_INT[1:0];
      idle_mode      = MODE_NUM;
    end else if (is_let) begin
      idle_hold_v    = 1'b1;
      idle_hold_kind = KIND_ID[1:0];
      idle_mode      = MODE_ID;
    end else begin
      case (char_code)
        CH_QUOTE: begin
          idle_str_clr = 1'b1;
          idle_mode    = MODE_STR;
        end
        CH_HASH:  idle_mode = MODE_LINE;
        CH_SLASH: idle_mode = MODE_SLASH;
        CH_EQ: begin
          idle_put_v = 1'b1;
          idle_kind  = KIND_EQUALS;
        end
        CH_SEMI: begin
          idle_put_v = 1'b1;
          idle_kind  = KIND_SEMI;
        end
        CH_LPAR: begin
          idle_put_v = 1'b1;
          idle_kind  = KIND_LPAREN;
        end
        CH_RPAR: begin
          idle_put_v = 1'b1;
          idle_kind  = KIND_RPAREN;
        end
        CH_COMMA: begin
          idle_put_v = 1'b1;
          idle_kind  = KIND_COMMA;
        end
        default: idle_mode = MODE_IDLE;
      endcase
    end
  end

  always_comb begin
    held_res.token_kind  = {2'b00, held_kind_r};
    held_res.text_char   = held_char_r;
    held_res.first_char  = held_first_r;
    held_res.last_char   = 1'b1;
    held_res.empty_token = 1'b0;
    held_res.last_of_run = 1'b0;

    idle_res.token_kind  = idle_kind;
    idle_res.text_char   = char_code;
    idle_res.first_char  = 1'b1;
    idle_res.last_char   = 1'b1;
    idle_res.empty_token = 1'b0;
    idle_res.last_of_run = 1'b0;

    empty_res.token_kind  = KIND_STRING;
    empty_res.text_char   = 8'h00;
    empty_res.first_char  = 1'b1;
    empty_res.last_char   = 1'b1;
    empty_res.empty_token = 1'b1;
    empty_res.last_of_run = 1'b0;

    eof_res            = empty_res;
    eof_res.token_kind = KIND_EOF;
  end

  always_comb begin
    a_v            = 1'b0;
    b_v            = 1'b0;
    a              = held_res;
    b              = idle_res;
    use_idle       = 1'b0;
    mode_nxt       = mode_r;
    held_valid_nxt = held_valid_r;
    held_char_nxt  = held_char_r;
    held_first_nxt = held_first_r;
    held_kind_nxt  = held_kind_r;
    str_text_nxt   = str_text_r;

    if (end_of_input) begin
      a_v = held_valid_r || (mode_r == MODE_STR);
      if (!held_valid_r) begin
        a = empty_res;
      end
      b_v            = 1'b1;
      b              = eof_res;
      mode_nxt       = MODE_IDLE;
      held_valid_nxt = 1'b0;
      held_char_nxt  = 8'h00;
      held_first_nxt = 1'b0;
      held_kind_nxt  = 2'b00;
      str_text_nxt   = 1'b0;
    end else begin
      case (mode_r)
        MODE_ID, MODE_NUM: begin
          a_v = held_valid_r;
          if (is_dig || (is_let && (mode_r == MODE_ID))) begin
            a.last_char    = 1'b0;
            held_valid_nxt = 1'b1;
            held_char_nxt  = char_code;
            held_first_nxt = 1'b0;
            held_kind_nxt  = (mode_r == MODE_ID) ? KIND_ID[1:0] : KIND_INT[1:0];
          end else begin
            use_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (char_code == CH_QUOTE) begin
            a_v = 1'b1;
            if (!held_valid_r) begin
              a = empty_res;
            end
            held_valid_nxt = 1'b0;
            str_text_nxt   = 1'b0;
            mode_nxt       = MODE_IDLE;
          end else begin
            a_v            = held_valid_r;
            a.last_char    = 1'b0;
            held_valid_nxt = 1'b1;
            held_char_nxt  = char_code;
            held_first_nxt = !str_text_r;
            held_kind_nxt  = KIND_STRING[1:0];
            str_text_nxt   = 1'b1;
          end
        end
        MODE_LINE: begin
          if (char_code == CH_NL) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_SLASH: begin
          if (char_code == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            use_idle = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (char_code == CH_STAR) begin
            mode_nxt = MODE_BLOCK_STAR;
          end
        end
        MODE_BLOCK_STAR: begin
          if (char_code == CH_SLASH) begin
            mode_nxt = MODE_IDLE;
          end else if (char_code != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        default: begin
          a_v      = held_valid_r;
          use_idle = 1'b1;
        end
      endcase

      if (use_idle) begin
        b_v      = idle_put_v;
        mode_nxt = idle_mode;
        if (idle_hold_v) begin
          held_valid_nxt = 1'b1;
          held_char_nxt  = char_code;
          held_first_nxt = 1'b1;
          held_kind_nxt  = idle_hold_kind;
        end else if (a_v) begin
          held_valid_nxt = 1'b0;
        end
        if (idle_str_clr) begin
          str_text_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    step = '0;
    if (a_v) begin
      step.res0  = a;
      step.res1  = b;
      step.count = b_v ? 2'd2 : 2'd1;
    end else begin
      step.res0  = b;
      step.res1  = b;
      step.count = b_v ? 2'd1 : 2'd0;
    end
    step.res0.last_of_run = (step.count == 2'd1);
    step.res1.last_of_run = 1'b1;
    push       = step;
    push.count = accept ? step.count : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      held_valid_r <= 1'b0;
      str_text_r   <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      held_valid_r <= held_valid_nxt;
      str_text_r   <= str_text_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_char_r  <= held_char_nxt;
      held_first_r <= held_first_nxt;
      held_kind_r  <= held_kind_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/st_resq.sv]
// ----------------------------------------------------------------------------
// st_resq
// Result queue: takes up to two results a cycle, hands out one a cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module st_resq import st_pkg::*; #(
  parameter int DEPTH = ST_RES_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output res_t  head,
  output logic  head_valid,
  output logic  no_room
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, wp1, wp2, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign wp1 = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign wp2 = (wp1  == PTR_W'(DEPTH - 1)) ? '0 : wp1 + 1'b1;

  always_comb begin
    case (push.count)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = wp2;
      default: wp_nxt = wp_r;
    endcase
    rp_nxt = rp_r;
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign no_room    = (cnt_r > CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wp1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/source_tokenizer.sv]
// Results of an accepted item are written into the result queue and shown on out_* from its head.
// Throughput: one item per cycle while in_stall is low; an item giving two results hands them out in turn.
// in_stall rises while the result queue has fewer than two free entries.
// Reset (synchronous, rst_n low) returns the scanner to idle and empties the queue.
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte in per item, token text out one char per item.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer import st_pkg::*; #(
  parameter int RES_DEPTH = ST_RES_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_first_char,
  output logic       out_last_char,
  output logic       out_empty_token,
  output logic       out_last_of_run
);

  logic  in_accept;
  logic  out_pop;
  push_t push;
  res_t  head;

  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid && !out_stall;

  st_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .char_code    (in_char_code),
    .end_of_input (in_end_of_input),
    .push         (push)
  );

  st_resq #(
    .DEPTH (RES_DEPTH)
  ) u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_pop),
    .head       (head),
    .head_valid (out_valid),
    .no_room    (in_stall)
  );

  assign out_token_kind  = head.token_kind;
  assign out_text_char   = head.text_char;
  assign out_first_char  = head.first_char;
  assign out_last_char   = head.last_char;
  assign out_empty_token = head.empty_token;
  assign out_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

[hw/rtl/st_checker.sv]
// ----------------------------------------------------------------------------
// st_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_tokenizer_macros.svh"

module st_checker import st_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_char_code,
  input wire logic       in_end_of_input,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] out_token_kind,
  input wire logic [7:0] out_text_char,
  input wire logic       out_first_char,
  input wire logic       out_last_char,
  input wire logic       out_empty_token,
  input wire logic       out_last_of_run
);

  `ST_ASSERT_NXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_char_code) && $stable(in_end_of_input),
    "input item changed while stalled")
  `ST_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_token_kind) && $stable(out_text_char),
    "result changed while stalled")
  `ST_ASSERT_IMP(a_eof_shape, out_valid && (out_token_kind == KIND_EOF),
    out_last_of_run && out_empty_token && out_first_char && out_last_char,
    "malformed end token")
  `ST_ASSERT_IMP(a_empty_shape, out_valid && out_empty_token,
    out_first_char && out_last_char && (out_text_char == 8'h00),
    "malformed empty token")
  `ST_ASSERT_IMP(a_punct_shape,
    out_valid && (out_token_kind >= KIND_EQUALS) && (out_token_kind <= KIND_COMMA),
    out_first_char && out_last_char && !out_empty_token,
    "malformed single-char token")

endmodule

bind source_tokenizer st_checker u_st_checker (.*);

`default_nettype wire
